### src/quiescent_state_grace_tracker_core_macros.svh
// Assertion macros for the quiescent state grace tracker checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef QUIESCENT_STATE_GRACE_TRACKER_CORE_MACROS_SVH
`define QUIESCENT_STATE_GRACE_TRACKER_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define QSGT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition implies another in the same cycle.
`define QSGT_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### src/qsgt_pkg.sv
// Shared constants, codes and types of the quiescent state grace tracker.
// No dependencies.
`default_nettype none

package qsgt_pkg;

  localparam int MaxContexts = 64;
  localparam int IdxW        = (MaxContexts > 1) ? $clog2(MaxContexts) : 1;
  localparam int CntW        = $clog2(MaxContexts + 1);
  localparam int FuncW       = 2;
  localparam int CtxFieldW   = 6;
  localparam int ErrW        = 2;
  localparam int CntFieldW   = 7;

  typedef enum logic [FuncW-1:0] {
    FnCreate  = 2'd0,
    FnDestroy = 2'd1,
    FnUpdate  = 2'd2,
    FnFlush   = 2'd3
  } func_e;

  typedef enum logic [ErrW-1:0] {
    ErrOk    = 2'd0,
    ErrFull  = 2'd1,
    ErrRange = 2'd2,
    ErrIdle  = 2'd3
  } err_e;

  typedef struct packed {
    logic capture;
    logic look;
    logic exec;
  } qsgt_cmd_t;

endpackage

`default_nettype wire

### src/qsgt_in_if.sv
// Request channel: valid/ready handshake carrying one operation.
// Depends on qsgt_pkg.
`default_nettype none

interface qsgt_in_if;
  import qsgt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FuncW-1:0]     func;
  logic [CtxFieldW-1:0] ctx_index;

  modport source (output valid, output func, output ctx_index, input ready);
  modport sink   (input valid, input func, input ctx_index, output ready);
endinterface

`default_nettype wire

### src/qsgt_out_if.sv
// Result channel: valid/ready handshake carrying one operation result.
// Depends on qsgt_pkg.
`default_nettype none

interface qsgt_out_if;
  import qsgt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CtxFieldW-1:0] assigned_context;
  logic                 grace_period_passed;
  logic                 released_all;
  logic [ErrW-1:0]      error_code;
  logic [CntFieldW-1:0] live_count;
  logic [CntFieldW-1:0] remaining_count;

  modport source (
    output valid, output assigned_context, output grace_period_passed,
    output released_all, output error_code, output live_count,
    output remaining_count, input ready
  );
  modport sink (
    input valid, input assigned_context, input grace_period_passed,
    input released_all, input error_code, input live_count,
    input remaining_count, output ready
  );
endinterface

`default_nettype wire

### src/qsgt_ctrl.sv
// Sequencer of the grace tracker: capture, free-list read, execute, hand off.
// Depends on qsgt_pkg.
`default_nettype none

module qsgt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qsgt_pkg::qsgt_cmd_t cmd_o
);
  import qsgt_pkg::*;

  typedef enum logic [1:0] {
    SIdle,
    SLook,
    SExec
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   exec_ok;

  assign exec_ok     = (state_q == SExec) && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;

  assign cmd_o.capture = in_valid_i && (state_q == SIdle);
  assign cmd_o.look    = (state_q == SLook);
  assign cmd_o.exec    = exec_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (exec_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            state_q <= SLook;
          end
        end
        SLook: begin
          state_q <= SExec;
        end
        SExec: begin
          if (exec_ok) begin
            state_q <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/qsgt_datapath.sv
// Context table, free list, counters and result register of the grace tracker.
// Depends on qsgt_pkg; driven by qsgt_ctrl commands.
`default_nettype none

module qsgt_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qsgt_pkg::qsgt_cmd_t           cmd_i,
  input  logic [qsgt_pkg::FuncW-1:0]    func_i,
  input  logic [qsgt_pkg::CtxFieldW-1:0] ctx_index_i,
  output logic [qsgt_pkg::CtxFieldW-1:0] assigned_context_o,
  output logic                          grace_period_passed_o,
  output logic                          released_all_o,
  output logic [qsgt_pkg::ErrW-1:0]     error_code_o,
  output logic [qsgt_pkg::CntFieldW-1:0] live_count_o,
  output logic [qsgt_pkg::CntFieldW-1:0] remaining_count_o
);
  import qsgt_pkg::*;

  localparam int CmpW = (CntW > CtxFieldW) ? CntW : CtxFieldW;

  func_e                op_q;
  logic [CtxFieldW-1:0] idx_q;
  logic [IdxW-1:0]      slot_next_free_q [MaxContexts];
  logic [IdxW-1:0]      next_q;

  logic [MaxContexts-1:0] in_use_q, in_use_d;
  logic [MaxContexts-1:0] quiet_q, quiet_d;
  logic [IdxW-1:0]        head_q, head_d;
  logic [CntW-1:0]        hw_q, hw_d;
  logic [CntW-1:0]        live_q, live_d;
  logic [CntW-1:0]        rem_q, rem_d;

  logic [CtxFieldW-1:0] assigned_q;
  logic                 grace_q;
  logic                 released_q;
  err_e                 err_q;

  logic [IdxW-1:0] slot;
  logic [IdxW-1:0] sel;
  logic            grace;
  logic            released;
  err_e            err;
  logic            push;

  assign sel = IdxW'(idx_q);

  always_comb begin
    in_use_d = in_use_q;
    quiet_d  = quiet_q;
    head_d   = head_q;
    hw_d     = hw_q;
    live_d   = live_q;
    rem_d    = rem_q;
    slot     = '0;
    grace    = 1'b0;
    released = 1'b0;
    err      = ErrOk;
    push     = 1'b0;
    case (op_q)
      FnCreate: begin
        if (live_q < hw_q) begin
          slot   = head_q;
          head_d = next_q;
        end else if (hw_q < CntW'(MaxContexts)) begin
          slot = IdxW'(hw_q);
          hw_d = hw_q + 1'b1;
        end else begin
          err = ErrFull;
        end
        if (err == ErrOk) begin
          in_use_d[slot] = 1'b1;
          quiet_d[slot]  = 1'b0;
          live_d         = live_q + 1'b1;
          rem_d          = rem_q + 1'b1;
        end
      end
      FnDestroy, FnUpdate: begin
        if (CmpW'(idx_q) >= CmpW'(hw_q)) begin
          err = ErrRange;
        end else if (!in_use_q[sel]) begin
          err = ErrIdle;
        end else if (op_q == FnDestroy) begin
          if (!quiet_q[sel] && (rem_q != '0)) begin
            rem_d = rem_q - 1'b1;
          end
          in_use_d[sel] = 1'b0;
          push          = 1'b1;
          head_d        = sel;
          live_d        = live_q - 1'b1;
          if (rem_d == '0) begin
            rem_d   = live_d;
            quiet_d = '0;
            grace   = 1'b1;
          end
        end else if (!quiet_q[sel]) begin
          quiet_d[sel] = 1'b1;
          if (rem_q != '0) begin
            rem_d = rem_q - 1'b1;
          end
          if (rem_d == '0) begin
            rem_d   = live_q;
            quiet_d = '0;
            grace   = 1'b1;
          end
        end
      end
      FnFlush: begin
        released = 1'b1;
        rem_d    = live_q;
      end
      default: begin
        err = ErrOk;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      quiet_q  <= '0;
      head_q   <= '0;
      hw_q     <= '0;
      live_q   <= '0;
      rem_q    <= '0;
    end else if (cmd_i.exec) begin
      in_use_q <= in_use_d;
      quiet_q  <= quiet_d;
      head_q   <= head_d;
      hw_q     <= hw_d;
      live_q   <= live_d;
      rem_q    <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= func_e'(func_i);
      idx_q <= ctx_index_i;
    end
    if (cmd_i.look) begin
      next_q <= slot_next_free_q[head_q];
    end
    if (cmd_i.exec && push) begin
      slot_next_free_q[sel] <= head_q;
    end
    if (cmd_i.exec) begin
      assigned_q <= CtxFieldW'(slot);
      grace_q    <= grace;
      released_q <= released;
      err_q      <= err;
    end
  end

  assign assigned_context_o    = assigned_q;
  assign grace_period_passed_o = grace_q;
  assign released_all_o        = released_q;
  assign error_code_o          = err_q;
  assign live_count_o          = CntFieldW'(live_q);
  assign remaining_count_o     = CntFieldW'(rem_q);

endmodule

`default_nettype wire

### src/quiescent_state_grace_tracker_core.sv
// Top level of the quiescent state grace tracker: sequencer plus datapath.
// Depends on qsgt_pkg, qsgt_in_if, qsgt_out_if, qsgt_ctrl, qsgt_datapath.
//
//   Channel | Dir | Payload
//   in_i    | in  | func, ctx_index
//   out_o   | out | assigned_context, grace_period_passed, released_all,
//           |     | error_code, live_count, remaining_count
//
// An operation goes from transfer in to result in three steps: capture,
// free-list memory read (registered), execute. The next request is taken once
// the operation has executed, so only one operation is in flight at a time.
// A result waiting on out_o holds only the execute step, not the capture.
// Reset empties the table, free list and counters at once; no clearing pass.
`default_nettype none

module quiescent_state_grace_tracker_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  qsgt_in_if.sink    in_i,
  qsgt_out_if.source out_o
);
  import qsgt_pkg::*;

  qsgt_cmd_t cmd;

  qsgt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  qsgt_datapath u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .func_i                (in_i.func),
    .ctx_index_i           (in_i.ctx_index),
    .assigned_context_o    (out_o.assigned_context),
    .grace_period_passed_o (out_o.grace_period_passed),
    .released_all_o        (out_o.released_all),
    .error_code_o          (out_o.error_code),
    .live_count_o          (out_o.live_count),
    .remaining_count_o     (out_o.remaining_count)
  );

endmodule

`default_nettype wire

### src/qsgt_checker.sv
// Port-level checks of the grace tracker result channel, bound to the top.
// Depends on qsgt_pkg and quiescent_state_grace_tracker_core_macros.svh.
`default_nettype none

`include "quiescent_state_grace_tracker_core_macros.svh"

module qsgt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [qsgt_pkg::CtxFieldW-1:0] assigned_context,
  input logic                           grace_period_passed,
  input logic                           released_all,
  input logic [qsgt_pkg::ErrW-1:0]      error_code,
  input logic [qsgt_pkg::CntFieldW-1:0] live_count,
  input logic [qsgt_pkg::CntFieldW-1:0] remaining_count
);
  import qsgt_pkg::*;

  `QSGT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(assigned_context) && $stable(error_code) && $stable(remaining_count), "stalled result changed")
  `QSGT_ASSERT_IMPLIES(a_grace_reload, out_valid && grace_period_passed, remaining_count == live_count, "grace period without reload")
  `QSGT_ASSERT_IMPLIES(a_flush, out_valid && released_all, remaining_count == live_count && !grace_period_passed && error_code == ErrOk, "bad flush result")
  `QSGT_ASSERT_IMPLIES(a_err_quiet, out_valid && error_code != ErrOk, assigned_context == '0 && !grace_period_passed && !released_all, "error result with side effects")

endmodule

bind quiescent_state_grace_tracker_core qsgt_checker u_qsgt_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid           (out_o.valid),
  .out_ready           (out_o.ready),
  .assigned_context    (out_o.assigned_context),
  .grace_period_passed (out_o.grace_period_passed),
  .released_all        (out_o.released_all),
  .error_code          (out_o.error_code),
  .live_count          (out_o.live_count),
  .remaining_count     (out_o.remaining_count)
);

`default_nettype wire
